>>> rtl/core/can_fast_packet_reassembler_macros.svh
// Assertion macros for the CAN fast-packet reassembler.
// No dependencies; included by the top level.
`ifndef CAN_FAST_PACKET_REASSEMBLER_MACROS_SVH
`define CAN_FAST_PACKET_REASSEMBLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CFPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfpr assertion failed");

// next-cycle implication, disabled during reset
`define CFPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfpr assertion failed");

`endif

>>> rtl/core/cfpr_pkg.sv
// Package for the CAN fast-packet reassembler: status codes, list codes,
// stream widths and the constant PGN lists with their lookup functions.
`default_nettype none

package cfpr_pkg;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 112;
    localparam int OUT_TUSER_W = 4;

    typedef enum logic [2:0] {
        ST_IGNORED     = 3'd0,
        ST_OTHER_UNIT  = 3'd1,
        ST_UNKNOWN     = 3'd2,
        ST_SINGLE_DONE = 3'd3,
        ST_FAST_START  = 3'd4,
        ST_FAST_CONT   = 3'd5,
        ST_FAST_DONE   = 3'd6,
        ST_SEQ_ERROR   = 3'd7
    } t_status;

    localparam logic [1:0] LIST_NONE = 2'd0;
    localparam logic [1:0] LIST_GPS  = 2'd1;
    localparam logic [1:0] LIST_AIS  = 2'd2;

    localparam logic USED_GPS = 1'b0;
    localparam logic USED_AIS = 1'b1;

    typedef struct packed {
        logic [16:0] pgn;
        logic        fast;
        logic        typed;
    } t_rom_entry;

    typedef struct packed {
        logic hit;
        logic fast;
        logic typed;
    } t_match;

    localparam int GPS_COUNT = 11;
    localparam int AIS_COUNT = 14;

    localparam t_rom_entry GPS_ROM [GPS_COUNT] = '{
        '{17'd59392,  1'b0, 1'b0}, '{17'd60928,  1'b0, 1'b0},
        '{17'd126208, 1'b0, 1'b0}, '{17'd126464, 1'b1, 1'b0},
        '{17'd126992, 1'b0, 1'b0}, '{17'd126996, 1'b1, 1'b0},
        '{17'd129025, 1'b0, 1'b1}, '{17'd129026, 1'b0, 1'b1},
        '{17'd129029, 1'b1, 1'b1}, '{17'd129539, 1'b0, 1'b1},
        '{17'd129540, 1'b1, 1'b1}
    };

    localparam t_rom_entry AIS_ROM [AIS_COUNT] = '{
        '{17'd59392,  1'b0, 1'b0}, '{17'd60928,  1'b0, 1'b0},
        '{17'd126208, 1'b0, 1'b0}, '{17'd126464, 1'b1, 1'b0},
        '{17'd126992, 1'b0, 1'b0}, '{17'd126996, 1'b1, 1'b0},
        '{17'd129038, 1'b1, 1'b1}, '{17'd129039, 1'b1, 1'b1},
        '{17'd129040, 1'b1, 1'b1}, '{17'd129794, 1'b1, 1'b1},
        '{17'd129798, 1'b1, 1'b1}, '{17'd129802, 1'b1, 1'b1},
        '{17'd129809, 1'b1, 1'b1}, '{17'd129810, 1'b1, 1'b1}
    };

    function automatic t_match gps_find(input logic [16:0] pgn);
        t_match m;
        m = '0;
        for (int i = 0; i < GPS_COUNT; i++) begin
            if (!m.hit && GPS_ROM[i].pgn == pgn) begin
                m = '{1'b1, GPS_ROM[i].fast, GPS_ROM[i].typed};
            end
        end
        return m;
    endfunction

    function automatic t_match ais_find(input logic [16:0] pgn);
        t_match m;
        m = '0;
        for (int i = 0; i < AIS_COUNT; i++) begin
            if (!m.hit && AIS_ROM[i].pgn == pgn) begin
                m = '{1'b1, AIS_ROM[i].fast, AIS_ROM[i].typed};
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/can_fast_packet_reassembler.sv
// Each frame passes through an input register and then a result register before its
// result transaction is offered. Throughput: one frame per cycle while the result side
// is not stalled, set by the single pass of PGN decode, parallel ROM match and offset
// arithmetic. Depends on cfpr_pkg and the macro header.
// Synchronous active-low reset clears both pipeline valids and all
// reassembly state (unit lock, list choice, sequence, offset, length).
`default_nettype none

`include "can_fast_packet_reassembler_macros.svh"

module can_fast_packet_reassembler (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] frame_id, [35:32] length_code, [99:36] frame_bytes, [103:100] zero
    input  wire logic [cfpr_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // [16:0] group_number, [24:17] source_address, [32:25] write_offset,
    // [36:33] byte_count, [100:37] payload, [108:101] message_length, [111:109] zero
    output logic [cfpr_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // [2:0] status, [3] list_used
    output logic [cfpr_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser
);
    import cfpr_pkg::*;

    logic        r_in_valid;
    logic [31:0] r_in_id;
    logic [3:0]  r_in_dlc;
    logic [63:0] r_in_data;

    logic        r_out_valid;
    t_status     r_out_status;
    logic [16:0] r_out_pgn;
    logic [7:0]  r_out_src;
    logic        r_out_used;
    logic [7:0]  r_out_woff;
    logic [3:0]  r_out_cnt;
    logic [63:0] r_out_pay;
    logic [7:0]  r_out_mlen;

    logic [7:0]  r_locked_unit;
    logic        r_unit_locked;
    logic [1:0]  r_list_choice;
    logic [8:0]  r_expected_seq;
    logic [7:0]  r_fill_offset;
    logic [7:0]  r_fast_length;

    t_status     n_status;
    logic [16:0] n_pgn;
    logic [7:0]  n_src;
    logic        n_used;
    logic [7:0]  n_woff;
    logic [3:0]  n_cnt;
    logic [63:0] n_pay;
    logic [7:0]  n_mlen;

    logic [7:0]  n_locked_unit;
    logic        n_unit_locked;
    logic [1:0]  n_list_choice;
    logic [8:0]  n_expected_seq;
    logic [7:0]  n_fill_offset;
    logic [7:0]  n_fast_length;

    logic        advance;
    logic        take;
    t_match      gps_m;
    t_match      ais_m;
    t_match      hit;
    logic [16:0] pgn_field;
    logic [7:0]  b0;
    logic [8:0]  room;
    logic [63:0] src_bytes;

    logic        out_single;
    logic        out_single_ok;
    logic        out_ignored;
    logic        out_ignored_ok;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign take            = advance && r_in_valid;
    assign o_s_axis_tready = !r_in_valid || advance;

    always_comb begin
        pgn_field      = r_in_id[24:8];
        n_status       = ST_IGNORED;
        n_pgn          = '0;
        n_src          = '0;
        n_used         = USED_GPS;
        n_woff         = '0;
        n_cnt          = '0;
        n_pay          = '0;
        n_mlen         = '0;
        n_locked_unit  = r_locked_unit;
        n_unit_locked  = r_unit_locked;
        n_list_choice  = r_list_choice;
        n_expected_seq = r_expected_seq;
        n_fill_offset  = r_fill_offset;
        n_fast_length  = r_fast_length;
        hit            = '0;
        b0             = r_in_data[7:0];
        room           = {1'b0, r_fast_length} - {1'b0, r_fill_offset};
        src_bytes      = r_in_data;

        if (pgn_field[16:8] < 9'd240) begin
            pgn_field[7:0] = '0;
        end
        gps_m = gps_find(pgn_field);
        ais_m = ais_find(pgn_field);

        if (r_in_id[31]) begin
            n_pgn = pgn_field;
            n_src = r_in_id[7:0];
            if (!r_unit_locked) begin
                n_locked_unit = r_in_id[7:0];
                n_unit_locked = 1'b1;
            end
            if (r_in_id[7:0] != n_locked_unit) begin
                n_status = ST_OTHER_UNIT;
            end else begin
                if (r_list_choice == LIST_GPS) begin
                    hit    = gps_m;
                    n_used = USED_GPS;
                end else if (r_list_choice != LIST_NONE) begin
                    hit    = ais_m;
                    n_used = USED_AIS;
                end else begin
                    if (gps_m.hit) begin
                        hit    = gps_m;
                        n_used = USED_GPS;
                    end else begin
                        hit    = ais_m;
                        n_used = USED_AIS;
                    end
                    if (hit.hit && hit.typed) begin
                        n_list_choice = (n_used == USED_AIS) ? LIST_AIS : LIST_GPS;
                    end
                end

                if (!hit.hit) begin
                    n_status = ST_UNKNOWN;
                    n_used   = USED_GPS;
                end else if (!hit.fast) begin
                    n_cnt          = (r_in_dlc > 4'd8) ? 4'd8 : r_in_dlc;
                    n_expected_seq = '0;
                    n_fill_offset  = {4'b0, n_cnt};
                    n_mlen         = {4'b0, n_cnt};
                    n_status       = ST_SINGLE_DONE;
                end else if (b0[4:0] == 5'd0) begin
                    n_fast_length  = r_in_data[15:8];
                    n_expected_seq = {1'b0, b0} + 9'd1;
                    n_fill_offset  = 8'd6;
                    n_cnt          = 4'd6;
                    src_bytes      = r_in_data >> 16;
                    n_status       = ST_FAST_START;
                end else if ({1'b0, b0} == r_expected_seq) begin
                    n_woff = r_fill_offset;
                    if (r_fast_length > r_fill_offset) begin
                        n_cnt = (room > 9'd7) ? 4'd7 : room[3:0];
                    end
                    n_fill_offset = r_fill_offset + {4'b0, n_cnt};
                    src_bytes     = r_in_data >> 8;
                    if (n_fill_offset == r_fast_length) begin
                        n_mlen        = r_fast_length;
                        n_fast_length = '0;
                        n_status      = ST_FAST_DONE;
                    end else begin
                        n_expected_seq = r_expected_seq + 9'd1;
                        n_status       = ST_FAST_CONT;
                    end
                end else begin
                    n_expected_seq = '0;
                    n_fast_length  = '0;
                    n_status       = ST_SEQ_ERROR;
                end

                for (int k = 0; k < 8; k++) begin
                    if (4'(k) < n_cnt) begin
                        n_pay[k*8 +: 8] = src_bytes[k*8 +: 8];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_locked_unit  <= '0;
            r_unit_locked  <= 1'b0;
            r_list_choice  <= LIST_NONE;
            r_expected_seq <= '0;
            r_fill_offset  <= '0;
            r_fast_length  <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (take) begin
                r_locked_unit  <= n_locked_unit;
                r_unit_locked  <= n_unit_locked;
                r_list_choice  <= n_list_choice;
                r_expected_seq <= n_expected_seq;
                r_fill_offset  <= n_fill_offset;
                r_fast_length  <= n_fast_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_id   <= i_s_axis_tdata[31:0];
            r_in_dlc  <= i_s_axis_tdata[35:32];
            r_in_data <= i_s_axis_tdata[99:36];
        end
        if (take) begin
            r_out_status <= n_status;
            r_out_pgn    <= n_pgn;
            r_out_src    <= n_src;
            r_out_used   <= n_used;
            r_out_woff   <= n_woff;
            r_out_cnt    <= n_cnt;
            r_out_pay    <= n_pay;
            r_out_mlen   <= n_mlen;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b0, r_out_mlen, r_out_pay, r_out_cnt, r_out_woff,
                              r_out_src, r_out_pgn};
    assign o_m_axis_tuser  = {r_out_used, r_out_status};

    assign out_single     = r_out_valid && r_out_status == ST_SINGLE_DONE;
    assign out_single_ok  = r_out_mlen == {4'b0, r_out_cnt} && r_out_woff == 8'd0;
    assign out_ignored    = r_out_valid && r_out_status == ST_IGNORED;
    assign out_ignored_ok = r_out_pgn == 17'd0 && r_out_cnt == 4'd0 && r_out_pay == 64'd0;

    `CFPR_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, r_out_valid, r_out_cnt <= 4'd8)
    `CFPR_ASSERT_IMPL(a_single_len, i_clk, i_rst_n, out_single, out_single_ok)
    `CFPR_ASSERT_IMPL(a_ignored_zero, i_clk, i_rst_n, out_ignored, out_ignored_ok)
    `CFPR_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n, take && n_status == ST_FAST_DONE, r_fast_length == 8'd0)

endmodule

`default_nettype wire

>>> tb/sv/can_fast_packet_reassembler_checker.sv
// Result checker for the CAN fast-packet reassembler: watches both stream channels,
// predicts one result per accepted frame and compares it field by field.
// Depends on cfpr_pkg for stream widths, status codes and list codes.
module can_fast_packet_reassembler_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_frame_valid,
    input  logic                             i_frame_ready,
    // [31:0] frame_id, [35:32] length_code, [99:36] frame_bytes, [103:100] zero
    input  logic [cfpr_pkg::IN_TDATA_W-1:0]  i_frame_data,
    input  logic                             i_result_valid,
    input  logic                             i_result_ready,
    // [16:0] group_number, [24:17] source_address, [32:25] write_offset,
    // [36:33] byte_count, [100:37] payload, [108:101] message_length, [111:109] zero
    input  logic [cfpr_pkg::OUT_TDATA_W-1:0] i_result_data,
    // [2:0] status, [3] list_used
    input  logic [cfpr_pkg::OUT_TUSER_W-1:0] i_result_user,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_completed
);
    timeunit 1ns;
    timeprecision 1ps;

    import cfpr_pkg::*;

    typedef struct packed {
        logic known;
        logic multi_frame;
        logic fixes_list;
    } t_pgn_kind;

    typedef struct packed {
        t_status     status;
        logic        used;
        logic [16:0] pgn;
        logic [7:0]  src;
        logic [7:0]  woff;
        logic [3:0]  cnt;
        logic [63:0] pay;
        logic [7:0]  mlen;
    } t_frame_result;

    logic [7:0] locked_src;
    logic       src_locked;
    logic [1:0] list_sel;
    logic [8:0] seq_expect;
    logic [7:0] fill_pos;
    logic [7:0] msg_len;

    t_frame_result awaited_results[$];
    int fail_count = 0;
    int checked    = 0;
    int completed  = 0;

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 40)
            $display("MISMATCH at %0t, result %0d: %s", $time, checked, what);
    endtask

    task automatic compare_field(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", field, got, want));
    endtask

    function automatic t_pgn_kind classify_pgn(input logic [16:0] pgn, input logic ais);
        t_pgn_kind kind;
        kind = '0;
        case (pgn)
            17'd59392, 17'd60928, 17'd126208, 17'd126992: kind = 3'b100;
            17'd126464, 17'd126996:                       kind = 3'b110;
            17'd129025, 17'd129026, 17'd129539:           if (!ais) kind = 3'b101;
            17'd129029, 17'd129540:                       if (!ais) kind = 3'b111;
            17'd129038, 17'd129039, 17'd129040, 17'd129794,
            17'd129798, 17'd129802, 17'd129809, 17'd129810: if (ais) kind = 3'b111;
            default: ;
        endcase
        return kind;
    endfunction

    function automatic logic [63:0] keep_low_bytes(input logic [63:0] v, input logic [3:0] n);
        logic [63:0] kept;
        kept = '0;
        for (int i = 0; i < 8; i++)
            if (i < n) kept[8*i +: 8] = v[8*i +: 8];
        return kept;
    endfunction

    function automatic t_frame_result reassemble_frame(input logic [31:0] id,
                                                       input logic [3:0]  dlc,
                                                       input logic [63:0] bytes);
        t_frame_result r;
        t_pgn_kind     kind;
        logic          from_ais;
        logic [7:0]    b0;
        r = '0;
        if (!id[31])
            return r;
        r.pgn = id[24:8];
        if (r.pgn[16:8] < 9'd240)
            r.pgn[7:0] = 8'd0;
        r.src = id[7:0];
        if (!src_locked) begin
            locked_src = id[7:0];
            src_locked = 1'b1;
        end
        if (r.src != locked_src) begin
            r.status = ST_OTHER_UNIT;
            return r;
        end

        if (list_sel == LIST_GPS) begin
            from_ais = USED_GPS;
            kind = classify_pgn(r.pgn, from_ais);
        end else if (list_sel != LIST_NONE) begin
            from_ais = USED_AIS;
            kind = classify_pgn(r.pgn, from_ais);
        end else begin
            from_ais = USED_GPS;
            kind = classify_pgn(r.pgn, from_ais);
            if (!kind.known) begin
                from_ais = USED_AIS;
                kind = classify_pgn(r.pgn, from_ais);
            end
            if (kind.known && kind.fixes_list)
                list_sel = (from_ais == USED_AIS) ? LIST_AIS : LIST_GPS;
        end
        if (!kind.known) begin
            r.status = ST_UNKNOWN;
            return r;
        end

        r.used = from_ais;
        b0 = bytes[7:0];
        if (!kind.multi_frame) begin
            r.cnt = (dlc > 4'd8) ? 4'd8 : dlc;
            seq_expect = '0;
            fill_pos = 8'(r.cnt);
            r.pay = keep_low_bytes(bytes, r.cnt);
            r.mlen = 8'(r.cnt);
            r.status = ST_SINGLE_DONE;
        end else if (b0[4:0] == 5'd0) begin
            msg_len = bytes[15:8];
            seq_expect = {1'b0, b0} + 9'd1;
            fill_pos = 8'd6;
            r.cnt = 4'd6;
            r.pay = {16'd0, bytes[63:16]};
            r.status = ST_FAST_START;
        end else if ({1'b0, b0} == seq_expect) begin
            r.woff = fill_pos;
            if (msg_len > fill_pos)
                r.cnt = (msg_len - fill_pos > 8'd7) ? 4'd7 : 4'(msg_len - fill_pos);
            fill_pos = fill_pos + 8'(r.cnt);
            r.pay = keep_low_bytes({8'd0, bytes[63:8]}, r.cnt);
            if (fill_pos == msg_len) begin
                r.mlen = msg_len;
                msg_len = '0;
                r.status = ST_FAST_DONE;
            end else begin
                seq_expect = seq_expect + 9'd1;
                r.status = ST_FAST_CONT;
            end
        end else begin
            seq_expect = '0;
            msg_len = '0;
            r.status = ST_SEQ_ERROR;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_frame_result want;
        if (!i_rst_n) begin
            locked_src = '0;
            src_locked = 1'b0;
            list_sel   = LIST_NONE;
            seq_expect = '0;
            fill_pos   = '0;
            msg_len    = '0;
            awaited_results.delete();
        end else begin
            if (i_result_valid && i_result_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result with no frame behind it, tdata %0h",
                                              i_result_data));
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", 64'(i_result_user[2:0]), 64'(want.status));
                    compare_field("list_used", 64'(i_result_user[3]), 64'(want.used));
                    compare_field("group_number", 64'(i_result_data[16:0]), 64'(want.pgn));
                    compare_field("source_address", 64'(i_result_data[24:17]), 64'(want.src));
                    compare_field("write_offset", 64'(i_result_data[32:25]), 64'(want.woff));
                    compare_field("byte_count", 64'(i_result_data[36:33]), 64'(want.cnt));
                    compare_field("payload", i_result_data[100:37], want.pay);
                    compare_field("message_length", 64'(i_result_data[108:101]),
                                  64'(want.mlen));
                    compare_field("tdata padding", 64'(i_result_data[111:109]), 64'd0);
                    checked++;
                    if (want.status inside {ST_SINGLE_DONE, ST_FAST_DONE})
                        completed++;
                end
            end
            // predict from the frame transaction after retiring the older result
            if (i_frame_valid && i_frame_ready)
                awaited_results.push_back(reassemble_frame(i_frame_data[31:0],
                                                           i_frame_data[35:32],
                                                           i_frame_data[99:36]));
        end
        o_fail_count <= fail_count;
        o_pending    <= awaited_results.size();
        o_checked    <= checked;
        o_completed  <= completed;
    end

endmodule

>>> tb/sv/can_fast_packet_reassembler_test.sv
// Top of the CAN fast-packet reassembler testbench: clock, reset, frame stimulus
// with bursty sending and result backpressure, and the final verdict.
// Depends on cfpr_pkg, the reassembler RTL and can_fast_packet_reassembler_checker.
module can_fast_packet_reassembler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cfpr_pkg::*;

    localparam int TOTAL_FRAMES = 450;

    typedef enum {CLEAN, SKIP_FRAME, BAD_SEQUENCE, FOREIGN_FRAME, SINGLE_INSIDE} t_msg_fault;
    typedef enum {NOISE_STANDARD, NOISE_OTHER_UNIT, NOISE_UNKNOWN, NOISE_RANDOM_ID} t_noise;
    typedef enum {READY_ALWAYS, READY_RANDOM, READY_SPARSE, READY_LONG_STALL} t_stall_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;

    int fail_count;
    int pending;
    int checked;
    int completed;

    logic [7:0] lock_src;
    logic       use_ais;
    int         burst_left  = 0;
    int         frames_sent = 0;
    int         unit_frames = 0;

    can_fast_packet_reassembler u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    can_fast_packet_reassembler_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_valid  (i_s_axis_tvalid),
        .i_frame_ready  (o_s_axis_tready),
        .i_frame_data   (i_s_axis_tdata),
        .i_result_valid (o_m_axis_tvalid),
        .i_result_ready (i_m_axis_tready),
        .i_result_data  (o_m_axis_tdata),
        .i_result_user  (o_m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_completed    (completed)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Timeout at %0t with %0d results outstanding", $time, pending);
        $display("can_fast_packet_reassembler_test failed");
        $finish;
    end

    initial begin : result_backpressure
        int          phase;
        t_stall_mode mode;
        i_m_axis_tready = 1'b0;
        phase = 0;
        mode  = READY_ALWAYS;
        forever begin
            @(negedge i_clk);
            if (phase % 64 == 0)
                mode = t_stall_mode'($urandom_range(0, 3));
            case (mode)
                READY_ALWAYS: i_m_axis_tready <= 1'b1;
                READY_RANDOM: i_m_axis_tready <= 1'($urandom);
                READY_SPARSE: i_m_axis_tready <= (phase % 4 == 0);
                default:      i_m_axis_tready <= (phase % 32 >= 19);
            endcase
            phase++;
        end
    end

    function automatic logic [16:0] pick_fast_pgn(input logic ais);
        case ($urandom_range(0, ais ? 9 : 3))
            0:       return 17'd126464;
            1:       return 17'd126996;
            2:       return ais ? 17'd129038 : 17'd129029;
            3:       return ais ? 17'd129039 : 17'd129540;
            4:       return 17'd129040;
            5:       return 17'd129794;
            6:       return 17'd129798;
            7:       return 17'd129802;
            8:       return 17'd129809;
            default: return 17'd129810;
        endcase
    endfunction

    function automatic logic [16:0] pick_single_pgn(input logic ais);
        case ($urandom_range(0, ais ? 3 : 6))
            0:       return 17'd59392;
            1:       return 17'd60928;
            2:       return 17'd126208;
            3:       return 17'd126992;
            4:       return 17'd129025;
            5:       return 17'd129026;
            default: return 17'd129539;
        endcase
    endfunction

    function automatic logic [31:0] make_id(input logic [16:0] pgn, input logic [7:0] src);
        logic [31:0] id;
        id = {1'b1, 6'($urandom), pgn, src};
        if (pgn[16:8] < 9'd240)
            id[15:8] = 8'($urandom);
        return id;
    endfunction

    task automatic send_frame(input logic [31:0] id, input logic [3:0] dlc,
                              input logic [63:0] bytes);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'd0, bytes, dlc, id};
        do @(posedge i_clk); while (!o_s_axis_tready);
        frames_sent++;
        if (id[31] && id[7:0] == lock_src)
            unit_frames++;
    endtask

    task automatic send_noise(input t_noise kind);
        logic [31:0] id;
        case (kind)
            NOISE_STANDARD:   id = {1'b0, 31'($urandom)};
            NOISE_OTHER_UNIT: id = make_id(pick_single_pgn(use_ais),
                                           lock_src ^ 8'($urandom_range(1, 255)));
            NOISE_UNKNOWN:    id = make_id(($urandom_range(0, 1) == 0) ?
                                           (use_ais ? 17'd129029 : 17'd129038) :
                                           17'($urandom), lock_src);
            default:          id = $urandom;
        endcase
        send_frame(id, 4'($urandom), {$urandom, $urandom});
    endtask

    task automatic send_message(input logic [16:0] pgn, input logic [7:0] len,
                                input t_msg_fault fault);
        logic [7:0] first_seq;
        logic [7:0] seq;
        int         conts;
        int         bad;
        first_seq = {3'($urandom), 5'd0};
        conts = (len <= 8'd6) ? 1 : len / 7;
        bad = $urandom_range(1, conts);
        send_frame(make_id(pgn, lock_src), 4'($urandom), {$urandom, 16'($urandom), len, first_seq});
        for (int k = 1; k <= conts; k++) begin
            seq = first_seq + 8'(k);
            if (k == bad) begin
                case (fault)
                    SKIP_FRAME:    continue;
                    BAD_SEQUENCE:  seq = seq ^ 8'($urandom_range(1, 31));
                    FOREIGN_FRAME: send_noise(t_noise'($urandom_range(0, 3)));
                    SINGLE_INSIDE: send_frame(make_id(pick_single_pgn(use_ais), lock_src),
                                              4'($urandom), {$urandom, $urandom});
                    default: ;
                endcase
            end
            send_frame(make_id(pgn, lock_src), 4'($urandom), {$urandom, 24'($urandom), seq});
        end
    endtask

    initial begin : stimulus
        logic [16:0] typed_fast;
        logic [16:0] other_typed;
        logic [7:0]  len;
        int          pick;
        int          wait_cycles;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        lock_src        = 8'($urandom);
        use_ais         = 1'($urandom);
        typed_fast      = use_ais ? 17'd129038 : 17'd129029;
        other_typed     = use_ais ? 17'd129029 : 17'd129038;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // standard frame first, so the unit lock comes from the next one
        send_frame({1'b0, 31'($urandom)}, 4'd15, '1);
        send_frame(make_id(17'd0, lock_src), 4'd0, '0);
        send_frame(make_id(17'd59392, lock_src ^ 8'h5a), 4'd8, '1);
        send_frame(make_id(17'd59392, lock_src), 4'd15, '1);
        send_frame(make_id(17'd126208, lock_src), 4'd0, '1);
        send_frame(make_id(17'd126992, lock_src), 4'd9, {$urandom, $urandom});
        send_message(17'd126996, 8'd0, CLEAN);
        send_message(typed_fast, 8'd13, CLEAN);
        send_frame(make_id(other_typed, lock_src), 4'd8, {$urandom, $urandom});
        send_message(17'd126464, 8'd6, CLEAN);
        send_message(typed_fast, 8'd20, BAD_SEQUENCE);
        send_message(typed_fast, 8'd3, CLEAN);
        send_frame(make_id(use_ais ? 17'd126208 : 17'd129539, lock_src), 4'd8, '0);
        send_message(typed_fast, 8'd27, SKIP_FRAME);

        while (frames_sent < TOTAL_FRAMES) begin
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(41, 255)) :
                                                8'($urandom_range(0, 40));
            if (pick < 55)
                send_message(pick_fast_pgn(use_ais), len, CLEAN);
            else if (pick < 70)
                send_message(pick_fast_pgn(use_ais), len, t_msg_fault'($urandom_range(1, 4)));
            else if (pick < 85)
                send_frame(make_id(pick_single_pgn(use_ais), lock_src), 4'($urandom),
                           {$urandom, $urandom});
            else
                send_noise(t_noise'($urandom_range(0, 3)));
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        // drain outstanding results, then hold a little for strays
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 4000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(negedge i_clk);

        $display("Sent %0d frames, %0d of them from locked unit %0h on the %s list",
                 frames_sent, unit_frames, lock_src, use_ais ? "AIS" : "GPS");
        $display("Checked %0d results, %0d single or fast-packet messages completed",
                 checked, completed);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("can_fast_packet_reassembler_test passed");
        else
            $display("can_fast_packet_reassembler_test failed");
        $finish;
    end

endmodule
